// ===== src/tvbm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvbm_pkg
// Shared types, codes and helpers of the touch virtual button mapper.
// ----------------------------------------------------------------------------
package tvbm_pkg;

    localparam int NUM_BUTTONS_DEF = 7;
    localparam int QUEUE_DEPTH_DEF = 4;

    // geometry width: holds 15*(4095+4095)+4095 and height-size-pad, signed
    localparam int GEO_W = 19;
    localparam int VAL_W = 32;
    localparam int CMP_W = 33;
    localparam int IDX_OUT_W = 3;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [11:0] SIZE_RST   = 12'd100;
    localparam logic [11:0] PAD_RST    = 12'd10;
    localparam logic [12:0] HEIGHT_RST = 13'd0;

    localparam logic [4:0] EVT_SYNC = 5'd0;
    localparam logic [4:0] EVT_ABS  = 5'd3;

    localparam logic [9:0] CODE_SYNC_REPORT = 10'h000;
    localparam logic [9:0] CODE_X           = 10'h035;
    localparam logic [9:0] CODE_Y           = 10'h036;
    localparam logic [9:0] CODE_TRACK       = 10'h039;
    localparam logic [9:0] CODE_PRESSURE    = 10'h03a;

    localparam logic [VAL_W-1:0] TRACK_NONE = '1;

    typedef enum logic [1:0] {
        REG_SIZE   = 2'd0,
        REG_PAD    = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    // one sync report: touch now and touch at the previous report
    typedef struct packed {
        logic [VAL_W-1:0] cur_x;
        logic [VAL_W-1:0] cur_y;
        logic             cur_down;
        logic [VAL_W-1:0] prev_x;
        logic [VAL_W-1:0] prev_y;
        logic             prev_down;
    } t_snap;

    // vertical span shared by every button
    typedef struct packed {
        logic [GEO_W-1:0] top;
        logic [GEO_W-1:0] bot;
    } t_geom;

    // inclusive signed range test of a coordinate
    function automatic logic in_span(input logic [VAL_W-1:0] v,
                                     input logic [GEO_W-1:0] lo,
                                     input logic [GEO_W-1:0] hi);
        logic signed [CMP_W-1:0] ev;
        logic signed [CMP_W-1:0] el;
        logic signed [CMP_W-1:0] eh;
        ev = signed'({{(CMP_W-VAL_W){v[VAL_W-1]}}, v});
        el = signed'({{(CMP_W-GEO_W){lo[GEO_W-1]}}, lo});
        eh = signed'({{(CMP_W-GEO_W){hi[GEO_W-1]}}, hi});
        return (ev >= el) && (ev <= eh);
    endfunction

endpackage
`default_nettype wire

// ===== src/tvbm_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvbm_cfg
// Register port and registered button geometry derived from it.
// ----------------------------------------------------------------------------
module tvbm_cfg #(
    parameter int NUM_BUTTONS = tvbm_pkg::NUM_BUTTONS_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      psel,
    input  wire logic                                      penable,
    input  wire logic                                      pwrite,
    input  wire logic [tvbm_pkg::CFG_ADDR_W-1:0]           paddr,
    input  wire logic [tvbm_pkg::CFG_DATA_W-1:0]           pwdata,
    output logic      [tvbm_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                           pready,
    output tvbm_pkg::t_geom                                o_geom,
    output logic      [NUM_BUTTONS-1:0][tvbm_pkg::GEO_W-1:0] o_left,
    output logic      [NUM_BUTTONS-1:0][tvbm_pkg::GEO_W-1:0] o_right
);
    import tvbm_pkg::*;

    logic [11:0] r_size;
    logic [11:0] r_pad;
    logic [12:0] r_height;
    t_reg_idx    w_idx;
    logic        w_wr;

    logic [GEO_W-1:0]                  w_stride;
    logic [NUM_BUTTONS-1:0][GEO_W-1:0] n_left;
    logic [NUM_BUTTONS-1:0][GEO_W-1:0] n_right;
    logic [NUM_BUTTONS-1:0][GEO_W-1:0] r_left;
    logic [NUM_BUTTONS-1:0][GEO_W-1:0] r_right;
    t_geom                             n_geom;
    t_geom                             r_geom;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= SIZE_RST;
            r_pad    <= PAD_RST;
            r_height <= HEIGHT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SIZE:   r_size   <= pwdata[11:0];
                REG_PAD:    r_pad    <= pwdata[11:0];
                REG_HEIGHT: r_height <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SIZE:   prdata = CFG_DATA_W'(r_size);
            REG_PAD:    prdata = CFG_DATA_W'(r_pad);
            REG_HEIGHT: prdata = CFG_DATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    assign w_stride = GEO_W'(r_size) + GEO_W'(r_pad);

    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            n_left[i]  = GEO_W'(GEO_W'(i) * w_stride);
            n_right[i] = n_left[i] + GEO_W'(r_size);
        end
        // top may go negative, two's complement
        n_geom.top = GEO_W'(r_height) - GEO_W'(r_size) - GEO_W'(r_pad);
        n_geom.bot = GEO_W'(r_height) - GEO_W'(r_pad);
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= n_right;
        r_geom  <= n_geom;
    end

    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_geom  = r_geom;

endmodule
`default_nettype wire

// ===== src/tvbm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvbm_front
// Takes input events, tracks the touch and hands sync reports to the queue.
// ----------------------------------------------------------------------------
module tvbm_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [4:0]                   i_event_type,
    input  wire logic [9:0]                   i_event_code,
    input  wire logic [tvbm_pkg::VAL_W-1:0]   i_event_value,
    input  wire logic                         i_q_full,
    output logic                              o_push,
    output tvbm_pkg::t_snap                   o_snap
);
    import tvbm_pkg::*;

    logic [VAL_W-1:0] r_x;
    logic [VAL_W-1:0] r_y;
    logic             r_down;
    logic [VAL_W-1:0] r_px;
    logic [VAL_W-1:0] r_py;
    logic             r_pdown;
    logic             w_acc;
    logic             w_abs;
    logic             w_sync;
    logic             w_neg;
    logic             w_zero;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;
    assign w_abs   = w_acc && (i_event_type == EVT_ABS);
    assign w_sync  = w_acc && (i_event_type == EVT_SYNC)
                     && (i_event_code == CODE_SYNC_REPORT);
    assign w_neg   = i_event_value[VAL_W-1];
    assign w_zero  = (i_event_value == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_down  <= 1'b0;
            r_px    <= '0;
            r_py    <= '0;
            r_pdown <= 1'b0;
        end else if (w_abs) begin
            priority case (i_event_code)
                CODE_X:     r_x <= i_event_value;
                CODE_Y:     r_y <= i_event_value;
                CODE_TRACK: r_down <= (i_event_value != TRACK_NONE);
                CODE_PRESSURE: begin
                    // negative pressure leaves the flag alone
                    if (!w_neg) begin
                        r_down <= !w_zero;
                    end
                end
                default: ;
            endcase
        end else if (w_sync) begin
            r_px    <= r_x;
            r_py    <= r_y;
            r_pdown <= r_down;
        end
    end

    assign o_push           = w_sync;
    assign o_snap.cur_x     = r_x;
    assign o_snap.cur_y     = r_y;
    assign o_snap.cur_down  = r_down;
    assign o_snap.prev_x    = r_px;
    assign o_snap.prev_y    = r_py;
    assign o_snap.prev_down = r_pdown;

endmodule
`default_nettype wire

// ===== src/tvbm_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvbm_queue
// Small fifo of sync reports between the front and the back.
// ----------------------------------------------------------------------------
module tvbm_queue #(
    parameter int DEPTH = tvbm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  tvbm_pkg::t_snap      i_snap,
    input  wire logic            i_pop,
    output tvbm_pkg::t_snap      o_snap,
    output logic                 o_full,
    output logic                 o_empty
);
    import tvbm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_snap            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_snap;
        end
    end

    assign o_snap = r_mem[r_rd];

endmodule
`default_nettype wire

// ===== src/tvbm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvbm_back
// Hit-tests queued sync reports and emits one button change per beat.
// ----------------------------------------------------------------------------
module tvbm_back #(
    parameter int NUM_BUTTONS = tvbm_pkg::NUM_BUTTONS_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  tvbm_pkg::t_snap                                  i_snap,
    input  wire logic                                        i_q_empty,
    output logic                                             o_pop,
    input  tvbm_pkg::t_geom                                  i_geom,
    input  wire logic [NUM_BUTTONS-1:0][tvbm_pkg::GEO_W-1:0] i_left,
    input  wire logic [NUM_BUTTONS-1:0][tvbm_pkg::GEO_W-1:0] i_right,
    output logic                                             o_valid,
    input  wire logic                                        i_ready,
    output logic [tvbm_pkg::IDX_OUT_W-1:0]                   o_button_index,
    output logic                                             o_is_press,
    output logic                                             o_last_of_run
);
    import tvbm_pkg::*;

    logic [NUM_BUTTONS-1:0] r_mask;
    logic [NUM_BUTTONS-1:0] r_now;
    logic [NUM_BUTTONS-1:0] w_now;
    logic [NUM_BUTTONS-1:0] w_was;
    logic [NUM_BUTTONS-1:0] w_mask_after;
    logic [IDX_OUT_W-1:0]   w_low_idx;
    logic                   w_low_press;
    logic                   w_out_free;
    logic                   w_emit;
    logic                   w_load;
    logic                   w_cur_y_in;
    logic                   w_prev_y_in;

    logic                   r_valid;
    logic [IDX_OUT_W-1:0]   r_idx;
    logic                   r_press;
    logic                   r_last;

    assign w_cur_y_in  = in_span(i_snap.cur_y, i_geom.top, i_geom.bot);
    assign w_prev_y_in = in_span(i_snap.prev_y, i_geom.top, i_geom.bot);

    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            w_now[i] = i_snap.cur_down && w_cur_y_in
                       && in_span(i_snap.cur_x, i_left[i], i_right[i]);
            w_was[i] = i_snap.prev_down && w_prev_y_in
                       && in_span(i_snap.prev_x, i_left[i], i_right[i]);
        end
    end

    // lowest pending button goes out first
    always_comb begin
        w_low_idx   = '0;
        w_low_press = 1'b0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_low_idx   = IDX_OUT_W'(i);
                w_low_press = r_now[i];
            end
        end
    end

    assign w_out_free   = !r_valid || i_ready;
    assign w_emit       = (r_mask != '0) && w_out_free;
    assign w_mask_after = w_emit ? (r_mask & (r_mask - 1'b1)) : r_mask;
    assign w_load       = !i_q_empty && (w_mask_after == '0);
    assign o_pop        = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mask <= w_load ? (w_now ^ w_was) : w_mask_after;
            if (w_out_free) begin
                r_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_now <= w_now;
        end
        if (w_emit) begin
            r_idx   <= w_low_idx;
            r_press <= w_low_press;
            r_last  <= (w_mask_after == '0);
        end
    end

    assign o_valid        = r_valid;
    assign o_button_index = r_idx;
    assign o_is_press     = r_press;
    assign o_last_of_run  = r_last;

endmodule
`default_nettype wire

// ===== src/touch_virtual_button_mapper_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// touch_virtual_button_mapper_unit
// Maps multitouch events onto press and release changes of a row of buttons.
//
//   channel   direction  signals                                    handshake
//   event     in         i_event_type, i_event_code, i_event_value  i_valid/o_ready
//   change    out        o_button_index, o_is_press, o_last_of_run  o_valid/i_ready
//   config    in/out     psel penable pwrite paddr pwdata prdata    pready high
//
// One event is taken per cycle while the report queue has room; axis events
// finish in that cycle. A sync report with k changed buttons gives k beats,
// one per cycle while i_ready is high, from the output register; a taken
// report passes the queue, then the change mask, then the output register.
// The report queue holds QUEUE_DEPTH reports, so events keep flowing while
// the output side stalls until it fills. Synchronous reset clears the touch
// state, the queue and the output; after a register write the geometry is
// registered again from the new register values.
// ----------------------------------------------------------------------------
module touch_virtual_button_mapper_unit #(
    parameter int NUM_BUTTONS = tvbm_pkg::NUM_BUTTONS_DEF,
    parameter int QUEUE_DEPTH = tvbm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [4:0]                         i_event_type,
    input  wire logic [9:0]                         i_event_code,
    input  wire logic [tvbm_pkg::VAL_W-1:0]         i_event_value,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [tvbm_pkg::IDX_OUT_W-1:0]          o_button_index,
    output logic                                    o_is_press,
    output logic                                    o_last_of_run,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tvbm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [tvbm_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [tvbm_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                    pready
);
    import tvbm_pkg::*;

    t_geom                             w_geom;
    logic [NUM_BUTTONS-1:0][GEO_W-1:0] w_left;
    logic [NUM_BUTTONS-1:0][GEO_W-1:0] w_right;
    t_snap                             w_push_snap;
    t_snap                             w_head_snap;
    logic                              w_push;
    logic                              w_pop;
    logic                              w_full;
    logic                              w_empty;

    tvbm_cfg #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (w_geom),
        .o_left  (w_left),
        .o_right (w_right)
    );

    tvbm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_event_type  (i_event_type),
        .i_event_code  (i_event_code),
        .i_event_value (i_event_value),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_snap        (w_push_snap)
    );

    tvbm_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_snap  (w_push_snap),
        .i_pop   (w_pop),
        .o_snap  (w_head_snap),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    tvbm_back #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_snap         (w_head_snap),
        .i_q_empty      (w_empty),
        .o_pop          (w_pop),
        .i_geom         (w_geom),
        .i_left         (w_left),
        .i_right        (w_right),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_button_index (o_button_index),
        .o_is_press     (o_is_press),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
`default_nettype wire
